[rtl/ccsm_pkg.sv]
// shared widths, character codes and status codes for the character-class mask parser
package ccsm_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned SET_SIZE   = 256;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_LOW_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ESC   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC_ESC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DANGLING  = 3'd4;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_WRITE_VALUE = 3'd0;

endpackage

[rtl/ccsm_if.sv]
// word channels of the character-class mask parser: string bytes in, status and mask out
interface ccsm_in_if;
    logic                              valid;
    logic                              ready;
    logic [ccsm_pkg::BYTE_W-1:0]       char_byte;
    logic                              last;

    modport source (output valid, output char_byte, output last, input ready);
    modport sink   (input valid, input char_byte, input last, output ready);
endinterface

interface ccsm_out_if;
    logic                              valid;
    logic                              ready;
    logic [ccsm_pkg::STATUS_W-1:0]     status;
    logic [ccsm_pkg::WORD_W-1:0]       mask_bits_0_63;
    logic [ccsm_pkg::WORD_W-1:0]       mask_bits_64_127;
    logic [ccsm_pkg::WORD_W-1:0]       mask_bits_128_191;
    logic [ccsm_pkg::WORD_W-1:0]       mask_bits_192_255;

    modport source (output valid, output status, output mask_bits_0_63,
                    output mask_bits_64_127, output mask_bits_128_191,
                    output mask_bits_192_255, input ready);
    modport sink   (input valid, input status, input mask_bits_0_63,
                    input mask_bits_64_127, input mask_bits_128_191,
                    input mask_bits_192_255, output ready);
endinterface

[rtl/char_class_string_to_mask_core.sv]
// top level of the character-class string to 256-bit membership mask parser
//
//  channel    | dir | word contents                        | notes
//  -----------+-----+--------------------------------------+---------------------------
//  char_in    | in  | char_byte[7:0], last                 | one string byte per word
//  mask_out   | out | status[2:0], mask_bits_* (4 x 64)    | one word per string (last)
//  apb        | in  | write_value at byte address 0        | pready always high
//
//  one byte per cycle unless a last byte waits on a stalled mask_out: a word is held in the
//  input register while the parser and the 256 parallel range compares update the mask
//  mask_out.valid is registered, set as the last byte of a string leaves the input register
//  rst_n clears the parser, sets the mask to all ones and write_value to one
//  a stalled mask_out only holds back a byte marked last; other bytes keep flowing
//  the mask is kept across strings, only the parser state clears after each last byte
module char_class_string_to_mask_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    ccsm_in_if.sink                           char_in,
    ccsm_out_if.source                        mask_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccsm_pkg::PADDR_W-1:0]      paddr,
    input  logic [ccsm_pkg::PDATA_W-1:0]      pwdata,
    output logic [ccsm_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    typedef enum logic [1:0]
    {
        PH_NORMAL,
        PH_ESCAPE,
        PH_HEX_HI,
        PH_HEX_LO
    } phase_t;

    // hex digit decode: 0-9, a-f, A-F
    function automatic logic hex_ok(input logic [ccsm_pkg::BYTE_W-1:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [ccsm_pkg::NIBBLE_W-1:0] hex_val(
        input logic [ccsm_pkg::BYTE_W-1:0] c);
        logic [ccsm_pkg::BYTE_W-1:0] d;
        d = 8'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h61 + 8'd10;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h41 + 8'd10;
        end
        hex_val = d[ccsm_pkg::NIBBLE_W-1:0];
    endfunction

    // configuration register
    logic                                   write_value_reg;
    logic                                   cfg_write;

    // input register
    logic                                   in_valid_reg;
    logic [ccsm_pkg::BYTE_W-1:0]            in_byte_reg;
    logic                                   in_last_reg;

    // parser state
    logic [ccsm_pkg::SET_SIZE-1:0]          mask_reg;
    logic [ccsm_pkg::SET_SIZE-1:0]          mask_next;
    logic [ccsm_pkg::BYTE_W-1:0]            range_low_reg, range_low_next;
    logic [ccsm_pkg::BYTE_W-1:0]            range_high_reg, range_high_next;
    logic                                   range_open_reg, range_open_next;
    phase_t                                 phase_reg, phase_next;
    logic [ccsm_pkg::NIBBLE_W-1:0]          nibble_reg, nibble_next;
    logic [ccsm_pkg::STATUS_W-1:0]          error_reg, error_next;

    // output register
    logic                                   out_valid_reg;
    logic [ccsm_pkg::STATUS_W-1:0]          out_status_reg;
    logic [ccsm_pkg::SET_SIZE-1:0]          out_mask_reg;

    logic                                   proc_fire;
    logic                                   name_en;
    logic [ccsm_pkg::BYTE_W-1:0]            name_val;
    logic                                   write_en;
    logic [ccsm_pkg::BYTE_W-1:0]            wr_low, wr_high;
    logic [ccsm_pkg::STATUS_W-1:0]          status_now;
    logic [ccsm_pkg::BYTE_W-1:0]            parse_low, parse_high;
    logic                                   parse_open;
    phase_t                                 parse_phase;
    logic [ccsm_pkg::NIBBLE_W-1:0]          parse_nibble;
    logic [ccsm_pkg::STATUS_W-1:0]          parse_error;

    // apb: single register, write in access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ccsm_pkg::ADDR_WRITE_VALUE);
    assign prdata    = (paddr == ccsm_pkg::ADDR_WRITE_VALUE)
                     ? {{(ccsm_pkg::PDATA_W-1){1'b0}}, write_value_reg}
                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_value_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            write_value_reg <= pwdata[0];
        end
    end

    // a byte leaves the input register unless it is a last byte facing a full output
    assign proc_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || mask_out.ready);
    assign char_in.ready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            in_byte_reg <= char_in.char_byte;
            in_last_reg <= char_in.last;
        end
    end

    // escape / range parser
    always_comb
    begin
        parse_low    = range_low_reg;
        parse_high   = range_high_reg;
        parse_open   = range_open_reg;
        parse_phase  = phase_reg;
        parse_nibble = nibble_reg;
        parse_error  = error_reg;
        name_en      = 1'b0;
        name_val     = in_byte_reg;

        // once an error is flagged every byte up to the last is dropped
        if (error_reg == ccsm_pkg::ST_OK)
        begin
            unique case (phase_reg)
                PH_NORMAL:
                begin
                    if (in_byte_reg == ccsm_pkg::CH_BSLASH)
                    begin
                        parse_phase = PH_ESCAPE;
                    end
                    else if (in_byte_reg == ccsm_pkg::CH_DASH)
                    begin
                        parse_open = 1'b1;
                    end
                    else if (in_byte_reg != ccsm_pkg::CH_SPACE)
                    begin
                        name_en = 1'b1;
                    end
                end
                PH_ESCAPE:
                begin
                    if (in_byte_reg == ccsm_pkg::CH_BSLASH || in_byte_reg == ccsm_pkg::CH_DASH)
                    begin
                        parse_phase = PH_NORMAL;
                        name_en     = 1'b1;
                    end
                    else if (in_byte_reg == ccsm_pkg::CH_LOW_X
                          || in_byte_reg == ccsm_pkg::CH_UP_X)
                    begin
                        parse_phase = PH_HEX_HI;
                    end
                    else
                    begin
                        parse_phase = PH_NORMAL;
                        parse_error = ccsm_pkg::ST_BAD_ESC;
                    end
                end
                PH_HEX_HI:
                begin
                    if (hex_ok(in_byte_reg))
                    begin
                        parse_nibble = hex_val(in_byte_reg);
                        parse_phase  = PH_HEX_LO;
                    end
                    else
                    begin
                        parse_phase = PH_NORMAL;
                        parse_error = ccsm_pkg::ST_BAD_HEX;
                    end
                end
                PH_HEX_LO:
                begin
                    parse_phase = PH_NORMAL;
                    if (hex_ok(in_byte_reg))
                    begin
                        name_en  = 1'b1;
                        name_val = {nibble_reg, hex_val(in_byte_reg)};
                    end
                    else
                    begin
                        parse_error = ccsm_pkg::ST_BAD_HEX;
                    end
                end
                default:
                begin
                    parse_phase = PH_NORMAL;
                end
            endcase
        end

        // a named byte closes an open range or stands alone
        if (name_en)
        begin
            parse_high = name_val;
            if (range_open_reg)
            begin
                parse_open = 1'b0;
            end
            else
            begin
                parse_low = name_val;
            end
        end
    end

    assign write_en = proc_fire && name_en;
    assign wr_low   = parse_low;
    assign wr_high  = parse_high;

    // 256 parallel compares; a reversed range matches no index
    always_comb
    begin
        for (int i = 0; i < ccsm_pkg::SET_SIZE; i++)
        begin
            if (write_en && (ccsm_pkg::BYTE_W'(i) >= wr_low) && (ccsm_pkg::BYTE_W'(i) <= wr_high))
            begin
                mask_next[i] = write_value_reg;
            end
            else
            begin
                mask_next[i] = mask_reg[i];
            end
        end
    end

    // end-of-string status, taken after this byte is parsed
    always_comb
    begin
        priority if (parse_error != ccsm_pkg::ST_OK)
        begin
            status_now = parse_error;
        end
        else if (parse_phase != PH_NORMAL)
        begin
            status_now = ccsm_pkg::ST_TRUNC_ESC;
        end
        else if (parse_open)
        begin
            status_now = ccsm_pkg::ST_DANGLING;
        end
        else
        begin
            status_now = ccsm_pkg::ST_OK;
        end
    end

    // the last byte resets the parser, the mask stays
    always_comb
    begin
        range_low_next  = parse_low;
        range_high_next = parse_high;
        range_open_next = parse_open;
        phase_next      = parse_phase;
        nibble_next     = parse_nibble;
        error_next      = parse_error;
        if (in_last_reg)
        begin
            range_low_next  = '0;
            range_high_next = '0;
            range_open_next = 1'b0;
            phase_next      = PH_NORMAL;
            nibble_next     = '0;
            error_next      = ccsm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '1;
            range_low_reg  <= '0;
            range_high_reg <= '0;
            range_open_reg <= 1'b0;
            phase_reg      <= PH_NORMAL;
            nibble_reg     <= '0;
            error_reg      <= ccsm_pkg::ST_OK;
        end
        else if (proc_fire)
        begin
            mask_reg       <= mask_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            range_open_reg <= range_open_next;
            phase_reg      <= phase_next;
            nibble_reg     <= nibble_next;
            error_reg      <= error_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (mask_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            out_status_reg <= status_now;
            out_mask_reg   <= mask_next;
        end
    end

    assign mask_out.valid             = out_valid_reg;
    assign mask_out.status            = out_status_reg;
    assign mask_out.mask_bits_0_63    = out_mask_reg[63:0];
    assign mask_out.mask_bits_64_127  = out_mask_reg[127:64];
    assign mask_out.mask_bits_128_191 = out_mask_reg[191:128];
    assign mask_out.mask_bits_192_255 = out_mask_reg[255:192];

    // a result word only appears after a last byte was parsed
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && in_last_reg))
        else $error("result word without a last byte");

    // the first error sticks until the string ends
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !in_last_reg && error_reg != ccsm_pkg::ST_OK)
        |=> (error_reg == $past(error_reg)))
        else $error("error code changed before end of string");

    // parser is clean after a last byte
    a_parser_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_last_reg)
        |=> (phase_reg == PH_NORMAL && !range_open_reg && error_reg == ccsm_pkg::ST_OK))
        else $error("parser state not cleared after last byte");

    // an empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> char_in.ready)
        else $error("input stalled with empty input register");

    // reported status stays within the defined codes
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg <= ccsm_pkg::ST_DANGLING))
        else $error("status code out of range");

endmodule
